// ----- src/dedup_pkg.sv -----
// dedup_pkg: sizes, operation codes and status codes of the deduplicating store.
// Standalone; used by dedup_with_index_remap_top.
package dedup_pkg;

  localparam int MAX_ITEMS = 256;
  localparam int ITEM_BITS = 64;

  // address into either store, and a total that can reach MAX_ITEMS
  localparam int ADDR_W = $clog2(MAX_ITEMS);
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);

  // port widths fixed by the interface
  localparam int KIND_W  = 2;
  localparam int IDX_W   = 8;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 9;

  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMAP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL       = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_LOADED = 2'd2;

endpackage

// ----- src/dedup_ram.sv -----
// dedup_ram: generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
module dedup_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/dedup_with_index_remap_top.sv -----
// dedup_with_index_remap_top: deduplicating item store with original-to-compact index map.
// Depends on dedup_pkg and two dedup_ram instances (unique items, index map).
//
//   channel | handshake          | payload
//   --------+--------------------+--------------------------------------------------
//   in      | in_valid/in_ready  | kind, item_value, query_index, query_unset
//   out     | out_valid/out_ready| status, compact_index, is_new, unique_count,
//           |                    | mapped_unset
//
// One word in flight. A load walks the unique store one entry per cycle through its
// single read port; a hit ends the walk early, and a load is not walked when the store
// is full. Remap of a loaded index makes one index map read; clear and other words go
// straight to the done state.
// rst is synchronous; memories have no reset, totals and control clear at once.
// A result waits in the output register; a new word is taken while it waits, but the
// next result holds in the done state until the output register frees up.
module dedup_with_index_remap_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dedup_pkg::KIND_W-1:0]  kind,
  input  logic [63:0]                   item_value,
  input  logic [dedup_pkg::IDX_W-1:0]   query_index,
  input  logic                          query_unset,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dedup_pkg::STAT_W-1:0]  status,
  output logic [dedup_pkg::IDX_W-1:0]   compact_index,
  output logic                          is_new,
  output logic [dedup_pkg::COUNT_W-1:0] unique_count,
  output logic                          mapped_unset
);

  localparam int QCMP_W = dedup_pkg::CNT_W + dedup_pkg::IDX_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_MAP  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;

  logic [dedup_pkg::CNT_W-1:0]     unique_total;
  logic [dedup_pkg::CNT_W-1:0]     loaded_total;
  logic [dedup_pkg::ITEM_BITS-1:0] item_r;
  logic [dedup_pkg::CNT_W-1:0]     issue_idx;
  logic [dedup_pkg::ADDR_W-1:0]    cmp_idx;
  logic                            rd_pend;

  logic [dedup_pkg::STAT_W-1:0]    res_status;
  logic [dedup_pkg::IDX_W-1:0]     res_idx;
  logic                            res_new;
  logic                            res_unset;

  logic [dedup_pkg::ITEM_BITS-1:0] store_rdata;
  logic [dedup_pkg::IDX_W-1:0]     map_rdata;
  logic                            store_we;
  logic                            map_we;
  logic [dedup_pkg::IDX_W-1:0]     map_wdata;

  logic accept;
  logic hit;
  logic more;
  logic miss;
  logic room;
  logic full;
  logic q_beyond;
  logic out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    hit      = (state == S_SCAN) && rd_pend && (store_rdata == item_r);
    more     = issue_idx < unique_total;
    miss     = (state == S_SCAN) && !hit && !more;
    room     = unique_total < dedup_pkg::CNT_W'(dedup_pkg::MAX_ITEMS);
    full     = loaded_total >= dedup_pkg::CNT_W'(dedup_pkg::MAX_ITEMS);
    q_beyond = QCMP_W'(query_index) >= QCMP_W'(loaded_total);
    store_we = miss && room;
    map_we   = hit || (miss && room);
    map_wdata = hit ? dedup_pkg::IDX_W'(cmp_idx) : dedup_pkg::IDX_W'(unique_total);
  end

  dedup_ram #(
    .WIDTH (dedup_pkg::ITEM_BITS),
    .DEPTH (dedup_pkg::MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (unique_total[dedup_pkg::ADDR_W-1:0]),
    .wdata (item_r),
    .raddr (issue_idx[dedup_pkg::ADDR_W-1:0]),
    .rdata (store_rdata)
  );

  dedup_ram #(
    .WIDTH (dedup_pkg::IDX_W),
    .DEPTH (dedup_pkg::MAX_ITEMS)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (loaded_total[dedup_pkg::ADDR_W-1:0]),
    .wdata (map_wdata),
    .raddr (dedup_pkg::ADDR_W'(query_index)),
    .rdata (map_rdata)
  );

  // control and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      unique_total <= '0;
      loaded_total <= '0;
      rd_pend      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            rd_pend <= 1'b0;
            case (kind)
              dedup_pkg::KIND_LOAD: begin
                state <= full ? S_DONE : S_SCAN;
              end
              dedup_pkg::KIND_REMAP: begin
                state <= (query_unset || q_beyond) ? S_DONE : S_MAP;
              end
              dedup_pkg::KIND_CLEAR: begin
                unique_total <= '0;
                loaded_total <= '0;
                state        <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (hit) begin
            loaded_total <= loaded_total + 1'b1;
            state        <= S_DONE;
          end else if (more) begin
            rd_pend <= 1'b1;
          end else begin
            if (room) begin
              unique_total <= unique_total + 1'b1;
              loaded_total <= loaded_total + 1'b1;
            end
            state <= S_DONE;
          end
        end
        S_MAP: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload: working word, scan pointers, result and output words
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r    <= item_value[dedup_pkg::ITEM_BITS-1:0];
      issue_idx <= '0;
      res_idx   <= '0;
      res_new   <= 1'b0;
      res_unset <= (kind == dedup_pkg::KIND_REMAP) && query_unset;
      if ((kind == dedup_pkg::KIND_LOAD) && full) begin
        res_status <= dedup_pkg::ST_FULL;
      end else if ((kind == dedup_pkg::KIND_REMAP) && !query_unset && q_beyond) begin
        res_status <= dedup_pkg::ST_NOT_LOADED;
      end else begin
        res_status <= dedup_pkg::ST_OK;
      end
    end
    if (state == S_SCAN) begin
      if (hit) begin
        res_idx <= dedup_pkg::IDX_W'(cmp_idx);
      end else if (more) begin
        // read issued this cycle; its data is compared next cycle
        cmp_idx   <= issue_idx[dedup_pkg::ADDR_W-1:0];
        issue_idx <= issue_idx + 1'b1;
      end else if (room) begin
        res_idx <= dedup_pkg::IDX_W'(unique_total);
        res_new <= 1'b1;
      end else begin
        res_status <= dedup_pkg::ST_FULL;
      end
    end
    if (state == S_MAP) begin
      res_idx <= map_rdata;
    end
    if ((state == S_DONE) && out_free) begin
      status        <= res_status;
      compact_index <= res_idx;
      is_new        <= res_new;
      unique_count  <= dedup_pkg::COUNT_W'(unique_total);
      mapped_unset  <= res_unset;
    end
  end

  a_totals_order: assert property (@(posedge clk) disable iff (rst)
    unique_total <= loaded_total)
    else $error("unique total exceeds loaded total");

  a_loaded_bound: assert property (@(posedge clk) disable iff (rst)
    loaded_total <= dedup_pkg::CNT_W'(dedup_pkg::MAX_ITEMS))
    else $error("loaded total beyond store depth");

  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    hit |-> (dedup_pkg::CNT_W'(cmp_idx) < unique_total))
    else $error("match reported on an entry not yet stored");

  a_new_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_new) |->
      (status == dedup_pkg::ST_OK) &&
      (compact_index == dedup_pkg::IDX_W'(unique_count - 1'b1)))
    else $error("new item not placed at the end of the unique store");

endmodule
